/* sv/tte_pkg.sv */
package tte_pkg;

    // Fixed point and counter widths
    localparam int TEMPO_FRAC_BITS = 16;
    localparam int FRAME_BITS      = 48;
    localparam int TEMPO_BITS      = 10 + TEMPO_FRAC_BITS;

    localparam int RATE_W   = 18;
    localparam int UNIT_W   = 7;
    localparam int BPB_W    = 5;
    localparam int STIFF_W  = 8;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;

    localparam int OFF_W    = 16;
    localparam int LEN_W    = 17;
    localparam int BPM_W    = 10;
    localparam int BEAT_W   = 16;
    localparam int BAR_W    = 32;
    localparam int POS_W    = 4;

    // 240 * sample_rate needs RATE_W + 8 bits; shifted left by the fraction
    localparam int NUM_W    = RATE_W + 8 + TEMPO_FRAC_BITS;
    localparam int DVD_W    = NUM_W;
    localparam int SM_W     = TEMPO_BITS + STIFF_W + 1;
    localparam int REM_W    = FRAME_BITS;
    localparam int CNT_W    = $clog2(DVD_W + 1);

    localparam logic [TEMPO_BITS-1:0] TEMPO_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_UNIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_BAR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS   = 2'd3;

    // Microcode
    localparam int OP_W = 4;
    localparam int JC_W = 2;
    localparam int PC_W = 4;

    localparam logic [OP_W-1:0] OP_END       = 4'd0;
    localparam logic [OP_W-1:0] OP_TAP_NOW   = 4'd1;
    localparam logic [OP_W-1:0] OP_TAP_INT   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV       = 4'd3;
    localparam logic [OP_W-1:0] OP_LOAD_BU   = 4'd4;
    localparam logic [OP_W-1:0] OP_RAW_SET   = 4'd5;
    localparam logic [OP_W-1:0] OP_RAW_MAX   = 4'd6;
    localparam logic [OP_W-1:0] OP_BLK_MUL   = 4'd7;
    localparam logic [OP_W-1:0] OP_BLK_LOAD  = 4'd8;
    localparam logic [OP_W-1:0] OP_SMOOTH    = 4'd9;
    localparam logic [OP_W-1:0] OP_REPORT    = 4'd10;
    localparam logic [OP_W-1:0] OP_FRAME_ADV = 4'd11;

    localparam logic [JC_W-1:0] JC_NEXT   = 2'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS = 2'd1;
    localparam logic [JC_W-1:0] JC_TEST   = 2'd2;

    localparam logic [PC_W-1:0] PC_TAP_NOW   = 4'd0;
    localparam logic [PC_W-1:0] PC_TAP_INT   = 4'd1;
    localparam logic [PC_W-1:0] PC_TAP_DIV   = 4'd2;
    localparam logic [PC_W-1:0] PC_LOAD_BU   = 4'd3;
    localparam logic [PC_W-1:0] PC_BU_DIV    = 4'd4;
    localparam logic [PC_W-1:0] PC_RAW_SET   = 4'd5;
    localparam logic [PC_W-1:0] PC_RAW_MAX   = 4'd6;
    localparam logic [PC_W-1:0] PC_BLK_MUL   = 4'd7;
    localparam logic [PC_W-1:0] PC_BLK_LOAD  = 4'd8;
    localparam logic [PC_W-1:0] PC_SM_DIV    = 4'd9;
    localparam logic [PC_W-1:0] PC_SMOOTH    = 4'd10;
    localparam logic [PC_W-1:0] PC_BAR_DIV   = 4'd11;
    localparam logic [PC_W-1:0] PC_REPORT    = 4'd12;
    localparam logic [PC_W-1:0] PC_END       = 4'd13;
    localparam logic [PC_W-1:0] PC_FRAME_ADV = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [JC_W-1:0] jc;
        logic [PC_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            PC_TAP_NOW:   w = '{op: OP_TAP_NOW,   jc: JC_NEXT,   target: PC_END};
            PC_TAP_INT:   w = '{op: OP_TAP_INT,   jc: JC_TEST,   target: PC_RAW_MAX};
            PC_TAP_DIV:   w = '{op: OP_DIV,       jc: JC_TEST,   target: PC_TAP_DIV};
            PC_LOAD_BU:   w = '{op: OP_LOAD_BU,   jc: JC_NEXT,   target: PC_END};
            PC_BU_DIV:    w = '{op: OP_DIV,       jc: JC_TEST,   target: PC_BU_DIV};
            PC_RAW_SET:   w = '{op: OP_RAW_SET,   jc: JC_ALWAYS, target: PC_END};
            PC_RAW_MAX:   w = '{op: OP_RAW_MAX,   jc: JC_ALWAYS, target: PC_END};
            PC_BLK_MUL:   w = '{op: OP_BLK_MUL,   jc: JC_NEXT,   target: PC_END};
            PC_BLK_LOAD:  w = '{op: OP_BLK_LOAD,  jc: JC_NEXT,   target: PC_END};
            PC_SM_DIV:    w = '{op: OP_DIV,       jc: JC_TEST,   target: PC_SM_DIV};
            PC_SMOOTH:    w = '{op: OP_SMOOTH,    jc: JC_TEST,   target: PC_FRAME_ADV};
            PC_BAR_DIV:   w = '{op: OP_DIV,       jc: JC_TEST,   target: PC_BAR_DIV};
            PC_REPORT:    w = '{op: OP_REPORT,    jc: JC_ALWAYS, target: PC_END};
            PC_FRAME_ADV: w = '{op: OP_FRAME_ADV, jc: JC_ALWAYS, target: PC_END};
            default:      w = '{op: OP_END,       jc: JC_NEXT,   target: PC_END};
        endcase
        return w;
    endfunction

endpackage

/* sv/tap_tempo_estimator.sv */
// A tap transfer keeps the block busy, before the next transfer is taken, through two
// 42-bit serial divisions, or through neither when the interval or beat unit is zero.
// A block end runs the smoothing division, and with a report also the bar division;
// the result enters the output register at the report step, which waits while held.
// Throughput: one item at a time, set by the one-bit-per-cycle shared divider.
// Reset: synchronous, active low; clears the sequencer, all tempo/position state.
module tap_tempo_estimator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tte_pkg::CFG_W-1:0]           i_cfg_data,

    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [tte_pkg::OFF_W-1:0]           i_tap_offset,
    input  logic [tte_pkg::LEN_W-1:0]           i_block_length,

    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tte_pkg::BPM_W-1:0]           o_tempo_bpm,
    output logic                                o_moving,
    output logic [tte_pkg::BAR_W-1:0]           o_bar_index,
    output logic [tte_pkg::POS_W-1:0]           o_beat_in_bar,
    output logic [tte_pkg::FRAME_BITS-1:0]      o_frame_position,
    output logic [tte_pkg::OFF_W-1:0]           o_report_offset
);

    localparam int F  = tte_pkg::TEMPO_FRAC_BITS;
    localparam int TB = tte_pkg::TEMPO_BITS;
    localparam int DW = tte_pkg::DVD_W;
    localparam int RW = tte_pkg::REM_W;
    localparam int CW = tte_pkg::CNT_W;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [tte_pkg::RATE_W-1:0]  r_sample_rate;
    logic [tte_pkg::UNIT_W-1:0]  r_beat_unit;
    logic [tte_pkg::BPB_W-1:0]   r_beats_per_bar;
    logic [tte_pkg::STIFF_W-1:0] r_stiffness;

    // ---------------------------------------------------------------------
    // Sequencer and captured item
    // ---------------------------------------------------------------------
    logic                        r_busy;
    logic [tte_pkg::PC_W-1:0]    r_pc;
    logic [tte_pkg::OFF_W-1:0]   r_offset;
    logic [tte_pkg::LEN_W-1:0]   r_len;

    // ---------------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------------
    logic [tte_pkg::FRAME_BITS-1:0] r_frame_count;
    logic [tte_pkg::FRAME_BITS-1:0] r_last_tap;
    logic [TB-1:0]                  r_raw;
    logic [TB-1:0]                  r_prev_raw;
    logic [TB-1:0]                  r_smoothed;
    logic [tte_pkg::BPM_W-1:0]      r_reported;
    logic [tte_pkg::BEAT_W-1:0]     r_beat_count;
    logic [tte_pkg::BAR_W-1:0]      r_bar_count;

    // ---------------------------------------------------------------------
    // Datapath scratch: shared restoring divider and smoothing operands
    // ---------------------------------------------------------------------
    logic [RW-1:0]               r_rem;
    logic [DW-1:0]               r_quo;
    logic [RW-1:0]               r_dsr;
    logic [CW-1:0]               r_cnt;
    logic [TB-1:0]               r_avg;
    logic [TB+tte_pkg::STIFF_W-1:0] r_prod;

    logic                        r_out_valid;
    logic [tte_pkg::BPM_W-1:0]   r_o_tempo;
    logic [tte_pkg::BAR_W-1:0]   r_o_bar;
    logic [tte_pkg::POS_W-1:0]   r_o_beat;
    logic [tte_pkg::FRAME_BITS-1:0] r_o_frame;
    logic [tte_pkg::OFF_W-1:0]   r_o_offset;

    // ---------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------
    tte_pkg::t_ctrl              w_ctrl;
    logic                        w_test;
    logic                        w_hold;
    logic                        w_accept;

    logic [RW:0]                 w_shift;
    logic                        w_ge;
    logic [RW:0]                 w_sub;

    logic [tte_pkg::RATE_W+7:0]  w_rate240;
    logic [DW-1:0]               w_num;
    logic [TB:0]                 w_avg_sum;
    logic [tte_pkg::STIFF_W-1:0] w_stiff;
    logic [tte_pkg::STIFF_W-1:0] w_stiff_m1;
    logic [tte_pkg::BPB_W-1:0]   w_bpb;
    logic [tte_pkg::SM_W-1:0]    w_sm_dvd;

    logic [TB-1:0]               w_sm_new;
    logic [TB-1:0]               w_ref_fx;
    logic [TB-1:0]               w_diff;
    logic                        w_report;
    logic [TB:0]                 w_round_sum;
    logic [TB-F:0]               w_rounded;
    logic [tte_pkg::BPM_W-1:0]   w_rep_new;

    assign w_ctrl   = tte_pkg::ctrl_rom(r_pc);
    assign w_accept = i_in_valid && !r_busy;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});
    assign w_sub   = w_shift - {1'b0, r_dsr};

    // tempo numerator 240 * rate * 2^F
    assign w_rate240 = (tte_pkg::RATE_W + 8)'(r_sample_rate) * (tte_pkg::RATE_W + 8)'(240);
    assign w_num     = {w_rate240, {F{1'b0}}};

    // effective stiffness and bar length
    assign w_stiff    = (r_stiffness == '0) ? tte_pkg::STIFF_W'(1) : r_stiffness;
    assign w_stiff_m1 = w_stiff - tte_pkg::STIFF_W'(1);
    assign w_bpb      = (r_beats_per_bar == '0) ? tte_pkg::BPB_W'(1) :
                        (r_beats_per_bar > tte_pkg::BPB_W'(16)) ? tte_pkg::BPB_W'(16) :
                        r_beats_per_bar;

    assign w_avg_sum = {1'b0, r_prev_raw} + {1'b0, r_raw};
    assign w_sm_dvd  = tte_pkg::SM_W'(r_avg) + tte_pkg::SM_W'(r_prod);

    // smoothing result straight out of the divider, and the report decision
    assign w_sm_new    = r_quo[TB-1:0];
    assign w_ref_fx    = {r_reported, {F{1'b0}}};
    assign w_diff      = (w_ref_fx > w_sm_new) ? (w_ref_fx - w_sm_new) : (w_sm_new - w_ref_fx);
    assign w_report    = |w_diff[TB-1:F];
    assign w_round_sum = {1'b0, w_sm_new} + (TB + 1)'(1 << (F - 1));
    assign w_rounded   = w_round_sum[TB:F];
    assign w_rep_new   = w_rounded[TB-F] ? '1 : w_rounded[tte_pkg::BPM_W-1:0];

    // per-step branch condition
    always_comb begin
        case (w_ctrl.op)
            tte_pkg::OP_DIV:     w_test = (r_cnt != CW'(1));
            tte_pkg::OP_TAP_INT: w_test = (r_dsr == r_last_tap) || (r_beat_unit == '0);
            tte_pkg::OP_SMOOTH:  w_test = !w_report;
            default:             w_test = 1'b0;
        endcase
    end

    // report step waits while the previous result still sits unread
    assign w_hold = (w_ctrl.op == tte_pkg::OP_REPORT) && r_out_valid && i_out_stall;

    // ---------------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate   <= tte_pkg::RATE_W'(48000);
            r_beat_unit     <= tte_pkg::UNIT_W'(4);
            r_beats_per_bar <= tte_pkg::BPB_W'(4);
            r_stiffness     <= tte_pkg::STIFF_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tte_pkg::CFG_SAMPLE_RATE: r_sample_rate   <= i_cfg_data[tte_pkg::RATE_W-1:0];
                tte_pkg::CFG_BEAT_UNIT:   r_beat_unit     <= i_cfg_data[tte_pkg::UNIT_W-1:0];
                tte_pkg::CFG_BEATS_BAR:   r_beats_per_bar <= i_cfg_data[tte_pkg::BPB_W-1:0];
                tte_pkg::CFG_STIFFNESS:   r_stiffness     <= i_cfg_data[tte_pkg::STIFF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Capture the transferred item; payload needs no reset
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_offset <= i_tap_offset;
            r_len    <= i_block_length;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: step counter with conditional jumps from the control ROM
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= tte_pkg::PC_END;
        end else if (!r_busy) begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pc   <= i_kind ? tte_pkg::PC_BLK_MUL : tte_pkg::PC_TAP_NOW;
            end
        end else if (!w_hold) begin
            if (w_ctrl.op == tte_pkg::OP_END) begin
                r_busy <= 1'b0;
            end else if ((w_ctrl.jc == tte_pkg::JC_ALWAYS) ||
                         ((w_ctrl.jc == tte_pkg::JC_TEST) && w_test)) begin
                r_pc <= w_ctrl.target;
            end else begin
                r_pc <= r_pc + tte_pkg::PC_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Architectural state updates, driven by the current control word
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_last_tap    <= '0;
            r_raw         <= '0;
            r_prev_raw    <= '0;
            r_smoothed    <= '0;
            r_reported    <= '0;
            r_beat_count  <= '0;
            r_bar_count   <= '0;
        end else if (r_busy && !w_hold) begin
            case (w_ctrl.op)
                tte_pkg::OP_TAP_INT: begin
                    // r_dsr still holds the tap frame here
                    r_last_tap   <= r_dsr;
                    r_beat_count <= r_beat_count + tte_pkg::BEAT_W'(1);
                end
                tte_pkg::OP_RAW_SET: begin
                    r_raw <= (|r_quo[DW-1:TB]) ? tte_pkg::TEMPO_MAX : r_quo[TB-1:0];
                end
                tte_pkg::OP_RAW_MAX: begin
                    r_raw <= tte_pkg::TEMPO_MAX;
                end
                tte_pkg::OP_BLK_LOAD: begin
                    r_prev_raw <= r_raw;
                end
                tte_pkg::OP_SMOOTH: begin
                    r_smoothed <= w_sm_new;
                    if (w_report) begin
                        r_reported <= w_rep_new;
                    end
                end
                tte_pkg::OP_REPORT: begin
                    r_bar_count   <= r_bar_count + tte_pkg::BAR_W'(r_quo[tte_pkg::BEAT_W-1:0]);
                    r_beat_count  <= r_rem[tte_pkg::BEAT_W-1:0];
                    r_frame_count <= r_frame_count + tte_pkg::FRAME_BITS'(r_len);
                end
                tte_pkg::OP_FRAME_ADV: begin
                    r_frame_count <= r_frame_count + tte_pkg::FRAME_BITS'(r_len);
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Divider and scratch registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_busy && !w_hold) begin
            case (w_ctrl.op)
                tte_pkg::OP_TAP_NOW: begin
                    // park the tap frame in the divisor register for one step
                    r_dsr <= r_frame_count + tte_pkg::FRAME_BITS'(r_offset);
                end
                tte_pkg::OP_TAP_INT: begin
                    r_dsr <= r_dsr - r_last_tap;
                    r_rem <= '0;
                    r_quo <= w_num;
                    r_cnt <= CW'(DW);
                end
                tte_pkg::OP_DIV: begin
                    r_rem <= w_ge ? w_sub[RW-1:0] : w_shift[RW-1:0];
                    r_quo <= {r_quo[DW-2:0], w_ge};
                    r_cnt <= r_cnt - CW'(1);
                end
                tte_pkg::OP_LOAD_BU: begin
                    r_dsr <= RW'(r_beat_unit);
                    r_rem <= '0;
                    r_cnt <= CW'(DW);
                end
                tte_pkg::OP_BLK_MUL: begin
                    r_avg  <= w_avg_sum[TB:1];
                    r_prod <= (TB + tte_pkg::STIFF_W)'(r_smoothed) *
                              (TB + tte_pkg::STIFF_W)'(w_stiff_m1);
                end
                tte_pkg::OP_BLK_LOAD: begin
                    r_dsr <= RW'(w_stiff);
                    r_rem <= '0;
                    r_quo <= DW'(w_sm_dvd) << (DW - tte_pkg::SM_W);
                    r_cnt <= CW'(tte_pkg::SM_W);
                end
                tte_pkg::OP_SMOOTH: begin
                    // beats into bars: beat_count / bpb
                    r_dsr <= RW'(w_bpb);
                    r_rem <= '0;
                    r_quo <= DW'(r_beat_count) << (DW - tte_pkg::BEAT_W);
                    r_cnt <= CW'(tte_pkg::BEAT_W);
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Output register: drop on transfer, load on the report step
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy && !w_hold && (w_ctrl.op == tte_pkg::OP_REPORT)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !w_hold && (w_ctrl.op == tte_pkg::OP_REPORT)) begin
            r_o_tempo  <= r_reported;
            r_o_bar    <= r_bar_count + tte_pkg::BAR_W'(r_quo[tte_pkg::BEAT_W-1:0]);
            r_o_beat   <= r_rem[tte_pkg::POS_W-1:0];
            r_o_frame  <= r_frame_count;
            r_o_offset <= (r_len == '0) ? '0 :
                          r_len[tte_pkg::OFF_W-1:0] - tte_pkg::OFF_W'(1);
        end
    end

    assign o_in_stall       = r_busy;
    assign o_out_valid      = r_out_valid;
    assign o_tempo_bpm      = r_o_tempo;
    assign o_moving         = (r_o_tempo != '0);
    assign o_bar_index      = r_o_bar;
    assign o_beat_in_bar    = r_o_beat;
    assign o_frame_position = r_o_frame;
    assign o_report_offset  = r_o_offset;

endmodule

/* sv/tte_checker.sv */
module tte_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [tte_pkg::BPM_W-1:0]      i_tempo_bpm,
    input  logic                           i_moving,
    input  logic [tte_pkg::FRAME_BITS-1:0] i_frame_position
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_tempo_bpm)
            && $stable(i_frame_position))
        else $error("stalled result changed");

    // moving flag follows the reported tempo
    a_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_moving == (i_tempo_bpm != '0)))
        else $error("moving flag disagrees with tempo");

    // every transfer occupies the sequencer for at least the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input not stalled after transfer");

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .i_in_stall       (o_in_stall),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_tempo_bpm      (o_tempo_bpm),
    .i_moving         (o_moving),
    .i_frame_position (o_frame_position)
);

/* dv/tap_tempo_estimator_tb.sv */
`timescale 1ns / 100ps

module tap_tempo_estimator_tb;

    // Item kinds on the input channel
    localparam bit KIND_TAP       = 1'b0;
    localparam bit KIND_BLOCK_END = 1'b1;

    localparam bit [63:0] TEMPO_CEIL = 64'(tte_pkg::TEMPO_MAX);
    localparam bit [63:0] TEMPO_ONE  = 64'd1 << tte_pkg::TEMPO_FRAC_BITS;
    localparam int        BPM_CEIL   = 1023;

    // A tap keeps the block busy through its two divisions and produces no report,
    // so give it this margin to settle before touching the registers.
    localparam int SETTLE_CYCLES = 128;
    // Cycles without any transfer before the run is declared hung
    localparam int STUCK_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 165;
    localparam int NUM_PHASES    = 9;

    typedef struct packed {
        logic [tte_pkg::BPM_W-1:0]      tempo_bpm;
        logic                           moving;
        logic [tte_pkg::BAR_W-1:0]      bar_index;
        logic [tte_pkg::POS_W-1:0]      beat_in_bar;
        logic [tte_pkg::FRAME_BITS-1:0] frame_position;
        logic [tte_pkg::OFF_W-1:0]      report_offset;
    } t_tempo_report;

    // Tempo tracker mirror: predicts reports from accepted items and checks
    // the reports the block hands out, oldest first.
    class tempo_scoreboard;
        bit [tte_pkg::RATE_W-1:0]     rate;
        bit [tte_pkg::UNIT_W-1:0]     unit;
        bit [tte_pkg::BPB_W-1:0]      bar_beats;
        bit [tte_pkg::STIFF_W-1:0]    stiffness;

        bit [tte_pkg::FRAME_BITS-1:0] frame_cnt;
        bit [tte_pkg::FRAME_BITS-1:0] last_tap;
        bit [63:0]                    raw;
        bit [63:0]                    prev_raw;
        bit [63:0]                    smooth;
        bit [tte_pkg::BPM_W-1:0]      shown_bpm;
        bit [tte_pkg::BEAT_W-1:0]     beats;
        bit [tte_pkg::BAR_W-1:0]      bars;

        t_tempo_report                due[$];
        int                           mismatches;

        function new();
            rate       = 48000;
            unit       = 4;
            bar_beats  = 4;
            stiffness  = 1;
            mismatches = 0;
        endfunction

        function void set_reg(logic [tte_pkg::CFG_IDX_W-1:0] idx, bit [tte_pkg::CFG_W-1:0] data);
            case (idx)
                tte_pkg::CFG_SAMPLE_RATE: rate      = data[tte_pkg::RATE_W-1:0];
                tte_pkg::CFG_BEAT_UNIT:   unit      = data[tte_pkg::UNIT_W-1:0];
                tte_pkg::CFG_BEATS_BAR:   bar_beats = data[tte_pkg::BPB_W-1:0];
                tte_pkg::CFG_STIFFNESS:   stiffness = data[tte_pkg::STIFF_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_item(bit kind, bit [tte_pkg::OFF_W-1:0] off,
                                bit [tte_pkg::LEN_W-1:0] len);
            bit [tte_pkg::FRAME_BITS-1:0] now;
            bit [tte_pkg::FRAME_BITS-1:0] span;
            bit [63:0]                    quo;
            bit [63:0]                    div_s;
            bit [63:0]                    bpb;
            bit [63:0]                    avg;
            bit [63:0]                    ref_fx;
            bit [63:0]                    diff;
            bit [63:0]                    rnd;
            t_tempo_report                r;
            if (kind == KIND_TAP) begin
                // Interval since the previous tap, modulo the frame counter width
                now      = frame_cnt + tte_pkg::FRAME_BITS'(off);
                span     = now - last_tap;
                last_tap = now;
                if (span == 0 || unit == 0) begin
                    raw = TEMPO_CEIL;
                end else begin
                    quo = ((64'd240 * 64'(rate)) << tte_pkg::TEMPO_FRAC_BITS) / 64'(span);
                    quo = quo / 64'(unit);
                    raw = (quo > TEMPO_CEIL) ? TEMPO_CEIL : quo;
                end
                beats = beats + tte_pkg::BEAT_W'(1);
            end else begin
                div_s = (stiffness == 0) ? 64'd1 : 64'(stiffness);
                bpb   = (bar_beats == 0) ? 64'd1 : ((bar_beats > 16) ? 64'd16 : 64'(bar_beats));
                avg      = (prev_raw + raw) >> 1;
                smooth   = (avg + smooth * (div_s - 1)) / div_s;
                prev_raw = raw;
                ref_fx   = 64'(shown_bpm) << tte_pkg::TEMPO_FRAC_BITS;
                diff     = (ref_fx > smooth) ? ref_fx - smooth : smooth - ref_fx;
                if (diff >= TEMPO_ONE) begin
                    rnd       = (smooth + (TEMPO_ONE >> 1)) >> tte_pkg::TEMPO_FRAC_BITS;
                    shown_bpm = (rnd > BPM_CEIL) ? tte_pkg::BPM_W'(BPM_CEIL)
                                                 : rnd[tte_pkg::BPM_W-1:0];
                    bars      = bars + tte_pkg::BAR_W'(64'(beats) / bpb);
                    beats     = tte_pkg::BEAT_W'(64'(beats) % bpb);
                    r.tempo_bpm      = shown_bpm;
                    r.moving         = (shown_bpm != 0);
                    r.bar_index      = bars;
                    r.beat_in_bar    = beats[tte_pkg::POS_W-1:0];
                    r.frame_position = frame_cnt;
                    r.report_offset  = (len == 0) ? '0
                                     : tte_pkg::OFF_W'(len - tte_pkg::LEN_W'(1));
                    due.push_back(r);
                end
                frame_cnt = frame_cnt + tte_pkg::FRAME_BITS'(len);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_tempo_report got);
            t_tempo_report want;
            if (due.size() == 0) begin
                $error("report with nothing expected: tempo_bpm %0d", got.tempo_bpm);
                mismatches++;
                return;
            end
            want = due.pop_front();
            compare_field("tempo_bpm", 64'(want.tempo_bpm), 64'(got.tempo_bpm));
            compare_field("moving", 64'(want.moving), 64'(got.moving));
            compare_field("bar_index", 64'(want.bar_index), 64'(got.bar_index));
            compare_field("beat_in_bar", 64'(want.beat_in_bar), 64'(got.beat_in_bar));
            compare_field("frame_position", 64'(want.frame_position),
                          64'(got.frame_position));
            compare_field("report_offset", 64'(want.report_offset),
                          64'(got.report_offset));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [tte_pkg::CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [tte_pkg::CFG_W-1:0]       i_cfg_data     = '0;
    logic                            i_in_valid     = 1'b0;
    logic                            o_in_stall;
    logic                            i_kind         = 1'b0;
    logic [tte_pkg::OFF_W-1:0]       i_tap_offset   = '0;
    logic [tte_pkg::LEN_W-1:0]       i_block_length = '0;
    logic                            o_out_valid;
    logic                            i_out_stall    = 1'b0;
    logic [tte_pkg::BPM_W-1:0]       o_tempo_bpm;
    logic                            o_moving;
    logic [tte_pkg::BAR_W-1:0]       o_bar_index;
    logic [tte_pkg::POS_W-1:0]       o_beat_in_bar;
    logic [tte_pkg::FRAME_BITS-1:0]  o_frame_position;
    logic [tte_pkg::OFF_W-1:0]       o_report_offset;

    tempo_scoreboard sb;
    int              items_sent  = 0;
    int              stuck_count = 0;
    // When clear, both sides run back to back without idle cycles
    bit              pace_idle   = 1'b1;

    tap_tempo_estimator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_tap_offset     (i_tap_offset),
        .i_block_length   (i_block_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tempo_bpm      (o_tempo_bpm),
        .o_moving         (o_moving),
        .o_bar_index      (o_bar_index),
        .o_beat_in_bar    (o_beat_in_bar),
        .o_frame_position (o_frame_position),
        .o_report_offset  (o_report_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: restart the count on every transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_count <= 0;
        end else if (stuck_count >= STUCK_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_count <= stuck_count + 1;
        end
    end

    // Report sink: hold stall for a random number of cycles, then take the
    // next report and hand it to the scoreboard.
    initial begin
        int unsigned   hold;
        t_tempo_report got;
        forever begin
            hold = pace_idle ? $urandom_range(0, 9) : 0;
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.tempo_bpm      = o_tempo_bpm;
            got.moving         = o_moving;
            got.bar_index      = o_bar_index;
            got.beat_in_bar    = o_beat_in_bar;
            got.frame_position = o_frame_position;
            got.report_offset  = o_report_offset;
            sb.check_report(got);
        end
    end

    // Drive one item and return at the edge that takes the transfer.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic send_item(bit kind, bit [tte_pkg::OFF_W-1:0] off,
                             bit [tte_pkg::LEN_W-1:0] len);
        int unsigned gap;
        gap = pace_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_tap_offset   <= off;
        i_block_length <= len;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_item(kind, off, len);
        items_sent++;
    endtask

    // Hold off the sender until every expected report is out, then let a
    // trailing tap finish its divisions.
    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(bit [tte_pkg::CFG_W-1:0] rate, bit [tte_pkg::CFG_W-1:0] unit,
                             bit [tte_pkg::CFG_W-1:0] bar_beats,
                             bit [tte_pkg::CFG_W-1:0] stiffness);
        logic [tte_pkg::CFG_IDX_W-1:0] idx_list [4];
        bit [tte_pkg::CFG_W-1:0]       vals [4];
        idx_list = '{tte_pkg::CFG_SAMPLE_RATE, tte_pkg::CFG_BEAT_UNIT,
                     tte_pkg::CFG_BEATS_BAR, tte_pkg::CFG_STIFFNESS};
        vals     = '{rate, unit, bar_beats, stiffness};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idx_list[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Steady tapping: a fixed tap period over a run of equal-length audio
    // blocks, with an occasional late tap to jolt the estimate.
    task automatic run_steady_episode();
        int unsigned period;
        int unsigned blk;
        int unsigned nblk;
        int unsigned phase;
        period = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 999)
                                              : $urandom_range(1000, 120000);
        blk = $urandom_range(period / 8 + 1, period * 2);
        if (blk > 65536) blk = 65536;
        nblk  = $urandom_range(4, 24);
        phase = $urandom_range(0, period);
        repeat (nblk) begin
            while (phase < blk) begin
                send_item(KIND_TAP, tte_pkg::OFF_W'(phase), tte_pkg::LEN_W'($urandom));
                phase += period;
                if ($urandom_range(0, 15) == 0) phase += $urandom_range(0, period / 4);
            end
            phase -= blk;
            send_item(KIND_BLOCK_END, tte_pkg::OFF_W'($urandom), tte_pkg::LEN_W'(blk));
        end
    endtask

    // Noise: taps anywhere in the 16-bit offset range, odd block lengths
    task automatic run_noise_burst();
        bit [tte_pkg::LEN_W-1:0] len;
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 0) begin
                send_item(KIND_TAP, tte_pkg::OFF_W'($urandom), tte_pkg::LEN_W'($urandom));
            end else begin
                case ($urandom_range(0, 7))
                    0:       len = '0;
                    1:       len = tte_pkg::LEN_W'(65536);
                    2, 3:    len = tte_pkg::LEN_W'($urandom_range(1, 64));
                    default: len = tte_pkg::LEN_W'($urandom_range(1, 65536));
                endcase
                send_item(KIND_BLOCK_END, tte_pkg::OFF_W'($urandom), len);
            end
        end
    endtask

    task automatic run_random(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            // Toggle pacing now and then so that long back-to-back stretches occur
            if ($urandom_range(0, 31) == 0) pace_idle = !pace_idle;
            if ($urandom_range(0, 4) != 0) run_steady_episode();
            else run_noise_burst();
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(48000, 4, 4, 1);

        // First tap lands on frame zero: zero interval, tempo saturates
        send_item(KIND_TAP, '0, '0);
        // Longest block, then a short one: tempo climbs and clips at 1023 bpm
        send_item(KIND_BLOCK_END, '0, tte_pkg::LEN_W'(65536));
        send_item(KIND_BLOCK_END, '1, tte_pkg::LEN_W'(1));
        // Tap far beyond the block, twice at the same frame
        send_item(KIND_TAP, '1, '1);
        send_item(KIND_TAP, '1, '0);
        // Zero-length block: position does not move
        send_item(KIND_BLOCK_END, '0, '0);
        // Tap behind the previous one: interval wraps, tempo drops to zero
        send_item(KIND_TAP, '0, '0);
        send_item(KIND_BLOCK_END, '0, tte_pkg::LEN_W'(4800));
        // Settle on 120 bpm with a tap at the start of every block
        repeat (4) begin
            send_item(KIND_TAP, '0, '0);
            send_item(KIND_BLOCK_END, '0, tte_pkg::LEN_W'(24000));
        end
        run_random(PHASE_ITEMS);

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            wait_for_reports();
            case (ph)
                1: configure(192000, 1, 16, 255);
                2: configure(8000, 64, 1, 1);
                // Zero rate, zero bar length, zero stiffness
                3: configure(0, 4, 0, 0);
                // Zero beat unit, bar length beyond sixteen
                4: configure(48000, 0, 31, 2);
                5: configure('h3FFFF, 'h7F, 'h1F, 'hFF);
                default: configure(tte_pkg::CFG_W'($urandom_range(8000, 192000)),
                                   tte_pkg::CFG_W'($urandom_range(1, 64)),
                                   tte_pkg::CFG_W'($urandom_range(1, 16)),
                                   ph[0] ? tte_pkg::CFG_W'($urandom_range(1, 255))
                                         : tte_pkg::CFG_W'($urandom_range(1, 6)));
            endcase
            run_random(PHASE_ITEMS);
        end

        wait_for_reports();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
